[sv/spdinv_pkg.sv]
// Shared types, constants and helpers for the Cholesky matrix inverter.
// Used by the divider, the square root unit and the top level; no dependencies.
`timescale 1ns / 1ps

package spdinv_pkg;

   localparam int MAX_ORDER = 8;
   localparam int FRAC_BITS = 16;
   localparam int IDX_W     = 3;
   localparam int ORD_W     = 4;
   localparam int ADDR_W    = 2 * IDX_W;
   localparam int DEPTH     = MAX_ORDER * MAX_ORDER;
   localparam int DATA_W    = 32;
   localparam int ACC_W     = 56;
   localparam int PROD_W    = 2 * DATA_W;

   typedef logic signed [DATA_W-1:0] word_type;
   typedef logic [ADDR_W-1:0]        addr_type;
   typedef logic [ORD_W-1:0]         ord_type;

   typedef enum logic [2:0] {
      PH_FDIAG,
      PH_FOFF,
      PH_IDIAG,
      PH_IOFF,
      PH_PROD
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_INIT2,
      ST_LOOP,
      ST_MUL,
      ST_ACC,
      ST_FINISH,
      ST_WAIT,
      ST_NEXT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic     start;
      word_type num;
      word_type den;
   } div_req_type;

   typedef struct packed {
      logic     start;
      word_type radicand;
   } sqrt_req_type;

   typedef struct packed {
      logic     done;
      word_type value;
   } unit_rsp_type;

   // Flat address of entry (r, c) in a MAX_ORDER by MAX_ORDER store.
   function automatic addr_type ent_addr(input ord_type r, input ord_type c);
      return {r[IDX_W-1:0], c[IDX_W-1:0]};
   endfunction

   // Saturate a wide accumulator to one word.
   function automatic word_type sat32(input logic signed [ACC_W-1:0] v);
      logic top_ones;
      logic top_zeros;
      top_ones  = &v[ACC_W-1:DATA_W-1];
      top_zeros = ~|v[ACC_W-1:DATA_W-1];
      if (top_ones || top_zeros) begin
         return v[DATA_W-1:0];
      end else if (v[ACC_W-1]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

endpackage

[sv/spdinv_ram.sv]
// Generic synchronous RAM: one write port, two read ports, registered reads.
// Self-contained; holds the matrix and the inverse factor stores.
`timescale 1ns / 1ps

module spdinv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write and both reads take effect at the clock edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

[sv/spdinv_div.sv]
// Restoring divider: rounded, saturated fixed-point quotient num / den, den > 0.
// Depends on spdinv_pkg; one quotient bit per cycle.
`timescale 1ns / 1ps

module spdinv_div (
   input  logic                      clock,
   input  logic                      reset,
   input  spdinv_pkg::div_req_type   req,
   output spdinv_pkg::unit_rsp_type  rsp
);
   import spdinv_pkg::*;

   localparam int DVD_W = DATA_W + FRAC_BITS + 1;
   localparam int CNT_W = $clog2(DVD_W + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DVD_W - 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] den_ff, den_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DATA_W:0]   rem_ff, rem_in;
   word_type          quot_ff, quot_in;

   logic [DATA_W-1:0] mag;
   logic [DATA_W:0]   rem_sh;
   logic              qbit;
   logic [DVD_W-1:0]  q_next;

   always_comb begin
      mag    = req.num[DATA_W-1] ? DATA_W'(-req.num) : DATA_W'(req.num);
      rem_sh = {rem_ff[DATA_W-1:0], dvd_ff[DVD_W-1]};
      qbit   = (rem_sh >= {1'b0, den_ff});
      q_next = {dvd_ff[DVD_W-2:0], qbit};

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      den_in  = den_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      quot_in = quot_ff;

      if (req.start) begin
         // Dividend is |num| scaled up plus half the divisor for rounding.
         run_in = 1'b1;
         cnt_in = '0;
         neg_in = req.num[DATA_W-1];
         den_in = DATA_W'(req.den);
         rem_in = '0;
         dvd_in = DVD_W'({mag, {FRAC_BITS{1'b0}}}) + DVD_W'(DATA_W'(req.den) >> 1);
      end else if (run_ff) begin
         rem_in = qbit ? (rem_sh - {1'b0, den_ff}) : rem_sh;
         dvd_in = q_next;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            // Apply the sign and saturate to one word.
            if (|q_next[DVD_W-1:DATA_W-1]) begin
               quot_in = neg_ff ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
            end else begin
               quot_in = neg_ff ? -q_next[DATA_W-1:0] : q_next[DATA_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      den_ff  <= den_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = quot_ff;

endmodule

[sv/spdinv_sqrt.sv]
// Digit-by-digit square root: floor(sqrt(radicand * 2^FRAC_BITS)).
// Depends on spdinv_pkg; one root bit per cycle.
`timescale 1ns / 1ps

module spdinv_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  spdinv_pkg::sqrt_req_type  req,
   output spdinv_pkg::unit_rsp_type  rsp
);
   import spdinv_pkg::*;

   localparam int V_W   = DATA_W + FRAC_BITS;
   localparam int STEPS = V_W / 2;
   localparam int CNT_W = $clog2(STEPS + 1);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(STEPS - 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [V_W-1:0]   rem_ff, rem_in;
   logic [V_W-1:0]   root_ff, root_in;
   logic [V_W-1:0]   bit_ff, bit_in;
   word_type         res_ff, res_in;

   logic [V_W-1:0] trial;
   logic [V_W-1:0] root_next;

   always_comb begin
      trial     = root_ff + bit_ff;
      root_next = (rem_ff >= trial) ? ((root_ff >> 1) + bit_ff) : (root_ff >> 1);

      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      res_in  = res_ff;

      if (req.start) begin
         run_in  = 1'b1;
         cnt_in  = '0;
         rem_in  = {req.radicand, {FRAC_BITS{1'b0}}};
         root_in = '0;
         bit_in  = V_W'(1) << (V_W - 2);
      end else if (run_ff) begin
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
         end
         root_in = root_next;
         bit_in  = bit_ff >> 2;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
            res_in  = DATA_W'(root_next);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      root_ff <= root_in;
      bit_ff  <= bit_in;
      res_ff  <= res_in;
   end

   assign rsp.done  = done_ff;
   assign rsp.value = res_ff;

endmodule

[sv/spd_matrix_cholesky_inverse.sv]
// Top level of the Cholesky inverter: load port, run sequencer, output stage.
// Depends on spdinv_pkg, spdinv_ram, spdinv_div and spdinv_sqrt.
//
//  Channel   Ports                                  Handshake
//  -------   -------------------------------------  ---------------------------
//  request   req_row_index .. req_load_done         start high, busy low
//  result    rsp_out_row .. rsp_last_result         rsp_valid strobe, one cycle
//  config    csr_wr_data (matrix order)             csr_wr_en high
//
// A loading transaction writes one element. The transaction with load_done then
// runs: each product term of a dot product passes ST_LOOP, ST_MUL and ST_ACC on
// the shared multiplier, each pivot root and each division waits on the
// iterative units, and each computed entry adds sequencing through ST_INIT,
// ST_INIT2, ST_FINISH and ST_NEXT; after the run n(n+1)/2 results leave one
// per cycle. Reset is synchronous; the stores need no clearing pass. Results
// cannot be stalled by the receiver.
`timescale 1ns / 1ps

module spd_matrix_cholesky_inverse (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_row_index,
   input  logic [2:0]                req_col_index,
   input  logic signed [31:0]        req_element_value,
   input  logic                      req_load_done,
   output logic                      rsp_valid,
   output logic [2:0]                rsp_out_row,
   output logic [2:0]                rsp_out_col,
   output logic signed [31:0]        rsp_out_value,
   output logic                      rsp_status,
   output logic                      rsp_last_result,
   input  logic                      csr_wr_en,
   input  logic [3:0]                csr_wr_data
);
   import spdinv_pkg::*;

   localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [ACC_W-1:0]         ONE_ACC    = ACC_W'(1) << FRAC_BITS;

   // Control registers
   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   ord_type   order_ff, order_in;
   ord_type   i_ff, i_in;
   ord_type   j_ff, j_in;
   ord_type   k_ff, k_in;
   logic      tag_vld_ff, tag_vld_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   word_type                 dvsr_ff, dvsr_in;
   logic [IDX_W-1:0]         tag_row_ff, tag_row_in;
   logic [IDX_W-1:0]         tag_col_ff, tag_col_in;
   logic                     tag_last_ff, tag_last_in;
   logic [IDX_W-1:0]         rsp_row_ff, rsp_row_in;
   logic [IDX_W-1:0]         rsp_col_ff, rsp_col_in;
   word_type                 rsp_value_ff, rsp_value_in;
   logic                     rsp_status_ff, rsp_status_in;
   logic                     rsp_last_ff, rsp_last_in;

   // Memory ports
   logic     ms_we, li_we;
   addr_type ms_waddr, li_waddr;
   word_type ms_wdata, li_wdata;
   addr_type ms_ra, ms_rb, li_ra, li_rb;
   word_type ms_rda, ms_rdb, li_rda, li_rdb;

   // Unit handshakes
   div_req_type  div_req;
   sqrt_req_type sqrt_req;
   unit_rsp_type div_rsp, sqrt_rsp;

   ord_type                  n_eff;
   ord_type                  kstart, kend;
   ord_type                  i_nx, j_nx;
   word_type                 sat_acc;
   word_type                 mul_a, mul_b;
   logic signed [PROD_W-1:0] term;
   logic                     unit_done;
   word_type                 unit_value;
   logic [IDX_W-1:0]         ld_row, ld_col;
   logic                     emit_last;

   spdinv_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_matrix_store (
      .clock     (clock),
      .wr_en     (ms_we),
      .wr_addr   (ms_waddr),
      .wr_data   (ms_wdata),
      .rd_addr_a (ms_ra),
      .rd_addr_b (ms_rb),
      .rd_data_a (ms_rda),
      .rd_data_b (ms_rdb)
   );

   spdinv_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_lower_inverse_store (
      .clock     (clock),
      .wr_en     (li_we),
      .wr_addr   (li_waddr),
      .wr_data   (li_wdata),
      .rd_addr_a (li_ra),
      .rd_addr_b (li_rb),
      .rd_data_a (li_rda),
      .rd_data_b (li_rdb)
   );

   spdinv_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   spdinv_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .rsp   (sqrt_rsp)
   );

   // Effective order, dot product bounds and operand routing per phase.
   always_comb begin
      if (order_ff == '0) begin
         n_eff = ORD_W'(1);
      end else if (order_ff > ORD_W'(MAX_ORDER)) begin
         n_eff = ORD_W'(MAX_ORDER);
      end else begin
         n_eff = order_ff;
      end

      i_nx = i_ff + 1'b1;
      j_nx = j_ff + 1'b1;

      unique case (phase_ff)
         PH_FDIAG, PH_FOFF: begin
            kstart = '0;
            kend   = j_ff;
            mul_a  = ms_rda;
            mul_b  = ms_rdb;
         end
         PH_IDIAG: begin
            kstart = j_ff;
            kend   = j_ff;
            mul_a  = ms_rda;
            mul_b  = li_rda;
         end
         PH_IOFF: begin
            kstart = j_ff;
            kend   = i_ff;
            mul_a  = ms_rda;
            mul_b  = li_rda;
         end
         default: begin
            kstart = i_ff;
            kend   = n_eff;
            mul_a  = li_rda;
            mul_b  = li_rdb;
         end
      endcase

      // Read addresses: operands while looping, otherwise the task entry and a diagonal entry.
      ms_ra = (state_ff == ST_LOOP) ? ent_addr(i_ff, k_ff) : ent_addr(i_ff, j_ff);
      if (state_ff == ST_LOOP) begin
         ms_rb = ent_addr(j_ff, k_ff);
      end else if (phase_ff == PH_FOFF) begin
         ms_rb = ent_addr(j_ff, j_ff);
      end else begin
         ms_rb = ent_addr(i_ff, i_ff);
      end
      li_ra = (phase_ff == PH_PROD) ? ent_addr(k_ff, i_ff) : ent_addr(k_ff, j_ff);
      li_rb = ent_addr(k_ff, j_ff);

      sat_acc    = sat32(acc_ff);
      prod_in    = PROD_W'(mul_a) * PROD_W'(mul_b);
      term       = (prod_ff + ROUND_HALF) >>> FRAC_BITS;
      unit_done  = (phase_ff == PH_FDIAG) ? sqrt_rsp.done : div_rsp.done;
      unit_value = (phase_ff == PH_FDIAG) ? sqrt_rsp.value : div_rsp.value;
      ld_row     = (req_col_index > req_row_index) ? req_col_index : req_row_index;
      ld_col     = (req_col_index > req_row_index) ? req_row_index : req_col_index;
      emit_last  = (i_ff == n_eff - 1'b1) && (j_ff == i_ff);
   end

   // Sequencer: next state, counters and memory writes.
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      order_in    = csr_wr_en ? csr_wr_data : order_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      acc_in      = acc_ff;
      dvsr_in     = dvsr_ff;
      tag_vld_in  = 1'b0;
      tag_row_in  = i_ff[IDX_W-1:0];
      tag_col_in  = j_ff[IDX_W-1:0];
      tag_last_in = emit_last;

      ms_we    = 1'b0;
      ms_waddr = ent_addr(i_ff, j_ff);
      ms_wdata = sat_acc;
      li_we    = 1'b0;
      li_waddr = ent_addr(i_ff, j_ff);
      li_wdata = unit_value;

      div_req.start     = 1'b0;
      div_req.num       = sat_acc;
      div_req.den       = dvsr_ff;
      sqrt_req.start    = 1'b0;
      sqrt_req.radicand = sat_acc;

      // Error result by default off; driven in the pivot check.
      rsp_valid_in  = tag_vld_ff;
      rsp_row_in    = tag_row_ff;
      rsp_col_in    = tag_col_ff;
      rsp_value_in  = ms_rda;
      rsp_status_in = 1'b0;
      rsp_last_in   = tag_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            // Store the element at its lower-triangle position.
            if (start) begin
               ms_we    = 1'b1;
               ms_waddr = {ld_row, ld_col};
               ms_wdata = req_element_value;
               if (req_load_done) begin
                  phase_in = PH_FDIAG;
                  i_in     = '0;
                  j_in     = '0;
                  state_in = ST_INIT;
               end
            end
         end
         ST_INIT: begin
            state_in = ST_INIT2;
         end
         ST_INIT2: begin
            // Seed the accumulator and latch the divisor of this task.
            unique case (phase_ff)
               PH_FDIAG, PH_FOFF: acc_in = ACC_W'(ms_rda);
               PH_IDIAG:          acc_in = ONE_ACC;
               default:           acc_in = '0;
            endcase
            dvsr_in  = ms_rdb;
            k_in     = kstart;
            state_in = ST_LOOP;
         end
         ST_LOOP: begin
            state_in = (k_ff == kend) ? ST_FINISH : ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = (phase_ff == PH_PROD) ? (acc_ff + ACC_W'(term)) : (acc_ff - ACC_W'(term));
            k_in     = k_ff + 1'b1;
            state_in = ST_LOOP;
         end
         ST_FINISH: begin
            unique case (phase_ff)
               PH_FDIAG: begin
                  // A pivot that is not strictly positive ends the run.
                  if (sat_acc <= 0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_row_in    = '0;
                     rsp_col_in    = '0;
                     rsp_value_in  = '0;
                     rsp_status_in = 1'b1;
                     rsp_last_in   = 1'b1;
                     state_in      = ST_IDLE;
                  end else begin
                     sqrt_req.start = 1'b1;
                     state_in       = ST_WAIT;
                  end
               end
               PH_PROD: begin
                  ms_we    = 1'b1;
                  state_in = ST_NEXT;
               end
               default: begin
                  div_req.start = 1'b1;
                  state_in      = ST_WAIT;
               end
            endcase
         end
         ST_WAIT: begin
            if (unit_done) begin
               if (phase_ff == PH_FDIAG || phase_ff == PH_FOFF) begin
                  ms_we    = 1'b1;
                  ms_wdata = unit_value;
               end else begin
                  li_we = 1'b1;
               end
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            // Move to the next entry of the factor, the inverse or the product.
            state_in = ST_INIT;
            unique case (phase_ff)
               PH_FDIAG: begin
                  if (j_nx < n_eff) begin
                     phase_in = PH_FOFF;
                     i_in     = j_nx;
                  end else begin
                     phase_in = PH_IDIAG;
                     i_in     = '0;
                     j_in     = '0;
                  end
               end
               PH_FOFF: begin
                  if (i_nx < n_eff) begin
                     i_in = i_nx;
                  end else if (j_nx < n_eff) begin
                     phase_in = PH_FDIAG;
                     i_in     = j_nx;
                     j_in     = j_nx;
                  end else begin
                     phase_in = PH_IDIAG;
                     i_in     = '0;
                     j_in     = '0;
                  end
               end
               PH_IDIAG: begin
                  if (j_nx < n_eff) begin
                     phase_in = PH_IOFF;
                     i_in     = j_nx;
                  end else begin
                     phase_in = PH_PROD;
                     i_in     = '0;
                     j_in     = '0;
                  end
               end
               PH_IOFF: begin
                  if (i_nx < n_eff) begin
                     i_in = i_nx;
                  end else if (j_nx < n_eff) begin
                     phase_in = PH_IDIAG;
                     i_in     = j_nx;
                     j_in     = j_nx;
                  end else begin
                     phase_in = PH_PROD;
                     i_in     = '0;
                     j_in     = '0;
                  end
               end
               default: begin
                  if (i_nx < n_eff) begin
                     i_in = i_nx;
                  end else if (j_nx < n_eff) begin
                     i_in = j_nx;
                     j_in = j_nx;
                  end else begin
                     i_in     = '0;
                     j_in     = '0;
                     state_in = ST_EMIT;
                  end
               end
            endcase
         end
         ST_EMIT: begin
            // One read per cycle, row by row over the lower triangle.
            tag_vld_in = 1'b1;
            if (emit_last) begin
               state_in = ST_IDLE;
            end else if (j_ff == i_ff) begin
               i_in = i_nx;
               j_in = '0;
            end else begin
               j_in = j_nx;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_FDIAG;
         order_ff     <= ORD_W'(MAX_ORDER);
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         tag_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         order_ff     <= order_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         tag_vld_ff   <= tag_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and output payload.
   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      dvsr_ff       <= dvsr_in;
      tag_row_ff    <= tag_row_in;
      tag_col_ff    <= tag_col_in;
      tag_last_ff   <= tag_last_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_row     = rsp_row_ff;
   assign rsp_out_col     = rsp_col_ff;
   assign rsp_out_value   = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule
